// ===== rtl/bbc_pkg.sv =====
// Package for the byte-budget LRU write-back cache directory.
// Holds sizes, codes, request/record types and the sequencer state type.
// No dependencies.
package bbc_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int MAX_REC  = ENTRIES + 1;
   localparam int OQ_AW    = $clog2(MAX_REC);
   localparam int OQ_DEPTH = 2 ** OQ_AW;

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_PUT    = 2'd1,
      OP_DELETE = 2'd2,
      OP_SYNC   = 2'd3
   } op_type;

   localparam logic [1:0] KIND_EVICT_CLEAN = 2'd0;
   localparam logic [1:0] KIND_EVICT_DIRTY = 2'd1;
   localparam logic [1:0] KIND_SYNC        = 2'd2;
   localparam logic [1:0] KIND_FINAL       = 2'd3;

   localparam logic [3:0] ST_HIT           = 4'd0;
   localparam logic [3:0] ST_MISS_FILLED   = 4'd1;
   localparam logic [3:0] ST_GET_BYPASS    = 4'd2;
   localparam logic [3:0] ST_PUT_CACHED    = 4'd3;
   localparam logic [3:0] ST_PUT_BYPASS    = 4'd4;
   localparam logic [3:0] ST_DEL_DIRTY     = 4'd5;
   localparam logic [3:0] ST_DEL_CLEAN     = 4'd6;
   localparam logic [3:0] ST_DEL_ABSENT    = 4'd7;
   localparam logic [3:0] ST_SYNC_DONE     = 4'd8;

   typedef struct packed {
      op_type      op;
      logic [63:0] key;
      logic [31:0] length;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key;
      logic [31:0] length;
      logic [3:0]  status;
      logic        last;
   } rec_type;

   typedef struct packed {
      logic        valid;
      logic        commit;
      rec_type     rec;
      logic [31:0] total;
   } rec_wr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_EVICT,
      S_INSERT,
      S_SYNC,
      S_FINAL
   } state_type;

endpackage

// ===== rtl/byte_budget_lru_writeback_cache.sv =====
// Top level of the byte-budget LRU write-back cache directory.
// Depends on bbc_pkg, bbc_front, bbc_back and bbc_outq.
//
//   channel   handshake        payload
//   request   push / full      req_operation, req_key, req_length
//   result    empty / pop      rsp_record_kind .. rsp_last
//   config    csr_we           csr_wdata (capacity in bytes)
//
// A request goes from lookup to its final record (get hit, bypass, delete),
// through eviction of one victim per step and an insertion, or through a sync
// step per valid entry; the back-end sequencer does one directory step a cycle.
// Records show on the result side only after their request's final record.
// Reset is synchronous and empties the directory; capacity resets to zero.
// A full result queue holds the sequencer before it takes the next request.
module byte_budget_lru_writeback_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_key,
   input  logic [31:0] req_length,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_record_kind,
   output logic [63:0] rsp_entry_key,
   output logic [31:0] rsp_entry_length,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_bytes_used,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import bbc_pkg::*;

   logic       q_valid, q_deq, room;
   req_type    q_req;
   rec_wr_type wr;
   rec_type    head;

   // front: hold up to two requests so the host can run ahead of the sequencer
   bbc_front u_front (
      .clock, .reset, .push, .full,
      .req_operation, .req_key, .req_length,
      .deq(q_deq), .head_valid(q_valid), .head(q_req)
   );

   // back: look up, evict, insert or sync, one record per cycle at most
   bbc_back u_back (
      .clock, .reset, .csr_we, .csr_wdata,
      .q_valid, .q_req, .q_deq, .room, .wr
   );

   // result queue: buffer whole requests so bytes_used is final on every record
   bbc_outq u_outq (
      .clock, .reset, .wr, .room, .empty, .pop,
      .head, .head_total(rsp_bytes_used)
   );

   assign rsp_record_kind  = head.kind;
   assign rsp_entry_key    = head.key;
   assign rsp_entry_length = head.length;
   assign rsp_status       = head.status;
   assign rsp_last         = head.last;

   // only the final record carries a status
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_last |-> rsp_status == ST_HIT)
      else $error("status on a non-final record");

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_record_kind == KIND_FINAL) == rsp_last))
      else $error("final kind and last disagree");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

endmodule

// ===== rtl/bbc_front.sv =====
// Front end: two-entry request queue that decodes the operation code.
// Depends on bbc_pkg.
module bbc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  logic [1:0]      req_operation,
   input  logic [63:0]     req_key,
   input  logic [31:0]     req_length,
   input  logic            deq,
   output logic            head_valid,
   output bbc_pkg::req_type head
);
   import bbc_pkg::*;

   req_type    slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = slot_ff[rp_ff];
   assign do_push    = push && !full;
   assign do_pop     = deq && head_valid;

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // decode the raw code into the operation type on the way in
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= '{op: op_type'(req_operation), key: req_key, length: req_length};
      end
   end

endmodule

// ===== rtl/bbc_back.sv =====
// Back end: directory state and the sequencer that carries out one request.
// Depends on bbc_pkg.
module bbc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [31:0]        csr_wdata,
   input  logic               q_valid,
   input  bbc_pkg::req_type   q_req,
   output logic               q_deq,
   input  logic               room,
   output bbc_pkg::rec_wr_type wr
);
   import bbc_pkg::*;

   state_type        state_ff, state_in;
   req_type          req_ff;
   logic [31:0]      cap_ff;
   logic [63:0]      key_mem [ENTRIES];
   logic [31:0]      len_mem [ENTRIES];
   logic             valid_ff [ENTRIES];
   logic             dirty_ff [ENTRIES];
   logic [IDX_W-1:0] rank_ff [ENTRIES];
   logic [31:0]      total_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [3:0]       status_ff;
   logic [31:0]      flen_ff;

   logic             hit_any, free_any;
   logic [IDX_W-1:0] hit_idx, victim_idx, sync_idx, free_idx, rd_idx;
   logic [31:0]      rd_len;
   logic             over_cap, need_evict, sync_busy;
   logic [32:0]      sum_used;

   always_comb begin
      hit_any    = 1'b0;
      hit_idx    = '0;
      victim_idx = '0;
      sync_idx   = '0;
      free_any   = 1'b0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_mem[i] == req_ff.key) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == IDX_W'(cnt_ff - CNT_W'(1))) begin
            victim_idx = IDX_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == IDX_W'(scan_ff)) begin
            sync_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // one read index on the length/key stores (the key match reads all keys)
   always_comb begin
      unique case (state_ff)
         S_LOOKUP: rd_idx = hit_idx;
         S_SYNC:   rd_idx = sync_idx;
         default:  rd_idx = victim_idx;
      endcase
   end

   assign rd_len     = len_mem[rd_idx];
   assign over_cap   = req_ff.length > cap_ff;
   assign sum_used   = {1'b0, total_ff} + {1'b0, req_ff.length};
   assign need_evict = (cnt_ff != '0) &&
                       (sum_used > {1'b0, cap_ff} || cnt_ff == CNT_W'(ENTRIES));
   assign sync_busy  = (scan_ff != cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && room) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            unique case (req_ff.op)
               OP_GET:    state_in = (hit_any || over_cap) ? S_FINAL : S_EVICT;
               OP_PUT:    state_in = over_cap ? S_FINAL : S_EVICT;
               OP_DELETE: state_in = S_FINAL;
               OP_SYNC:   state_in = S_SYNC;
               default:   state_in = S_FINAL;
            endcase
         end
         S_EVICT: begin
            if (!need_evict) state_in = S_INSERT;
         end
         S_INSERT: state_in = S_FINAL;
         S_SYNC: begin
            if (!sync_busy) state_in = S_FINAL;
         end
         S_FINAL: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_deq = 1'b0;
      wr    = '0;
      wr.total = total_ff;
      unique case (state_ff)
         S_IDLE: q_deq = q_valid && room;
         S_EVICT: begin
            wr.valid      = need_evict;
            wr.rec.kind   = dirty_ff[victim_idx] ? KIND_EVICT_DIRTY : KIND_EVICT_CLEAN;
            wr.rec.key    = key_mem[rd_idx];
            wr.rec.length = rd_len;
         end
         S_SYNC: begin
            wr.valid      = sync_busy && dirty_ff[sync_idx];
            wr.rec.kind   = KIND_SYNC;
            wr.rec.key    = key_mem[rd_idx];
            wr.rec.length = rd_len;
         end
         S_FINAL: begin
            wr.valid      = 1'b1;
            wr.commit     = 1'b1;
            wr.rec.kind   = KIND_FINAL;
            wr.rec.key    = req_ff.key;
            wr.rec.length = flen_ff;
            wr.rec.status = status_ff;
            wr.rec.last   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (q_deq) req_ff <= q_req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= '0;
         total_ff <= '0;
         cnt_ff   <= '0;
         scan_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         if (csr_we) cap_ff <= csr_wdata;
         unique case (state_ff)
            S_LOOKUP: begin
               scan_ff <= '0;
               if (hit_any && req_ff.op == OP_GET) begin
                  // touch: entries more recent than the hit age by one
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && IDX_W'(i) != hit_idx && rank_ff[i] < rank_ff[hit_idx])
                        rank_ff[i] <= rank_ff[i] + IDX_W'(1);
                  end
                  rank_ff[hit_idx] <= '0;
               end else if (hit_any && (req_ff.op == OP_PUT || req_ff.op == OP_DELETE)) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && IDX_W'(i) != hit_idx && rank_ff[i] > rank_ff[hit_idx])
                        rank_ff[i] <= rank_ff[i] - IDX_W'(1);
                  end
                  valid_ff[hit_idx] <= 1'b0;
                  dirty_ff[hit_idx] <= 1'b0;
                  rank_ff[hit_idx]  <= '0;
                  total_ff <= total_ff - rd_len;
                  cnt_ff   <= cnt_ff - CNT_W'(1);
               end
            end
            S_EVICT: begin
               if (need_evict) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && IDX_W'(i) != victim_idx &&
                         rank_ff[i] > rank_ff[victim_idx])
                        rank_ff[i] <= rank_ff[i] - IDX_W'(1);
                  end
                  valid_ff[victim_idx] <= 1'b0;
                  dirty_ff[victim_idx] <= 1'b0;
                  rank_ff[victim_idx]  <= '0;
                  total_ff <= total_ff - rd_len;
                  cnt_ff   <= cnt_ff - CNT_W'(1);
               end
            end
            S_INSERT: begin
               if (free_any) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + IDX_W'(1);
                  end
                  valid_ff[free_idx] <= 1'b1;
                  dirty_ff[free_idx] <= (req_ff.op == OP_PUT);
                  rank_ff[free_idx]  <= '0;
                  total_ff <= total_ff + req_ff.length;
                  cnt_ff   <= cnt_ff + CNT_W'(1);
               end
            end
            S_SYNC: begin
               if (sync_busy) begin
                  dirty_ff[sync_idx] <= 1'b0;
                  scan_ff <= scan_ff + CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // payload: stores, final status and length
   always_ff @(posedge clock) begin
      if (state_ff == S_INSERT && free_any) begin
         key_mem[free_idx] <= req_ff.key;
         len_mem[free_idx] <= req_ff.length;
      end
      if (state_ff == S_LOOKUP) begin
         flen_ff <= req_ff.length;
         unique case (req_ff.op)
            OP_GET: begin
               if (hit_any) begin
                  flen_ff   <= rd_len;
                  status_ff <= ST_HIT;
               end else begin
                  status_ff <= over_cap ? ST_GET_BYPASS : ST_MISS_FILLED;
               end
            end
            OP_PUT: status_ff <= over_cap ? ST_PUT_BYPASS : ST_PUT_CACHED;
            OP_DELETE: begin
               if (hit_any) begin
                  flen_ff   <= rd_len;
                  status_ff <= dirty_ff[hit_idx] ? ST_DEL_DIRTY : ST_DEL_CLEAN;
               end else begin
                  status_ff <= ST_DEL_ABSENT;
               end
            end
            default: status_ff <= ST_SYNC_DONE;
         endcase
      end
   end

endmodule

// ===== rtl/bbc_outq.sv =====
// Result queue: records become visible only once their request is committed.
// Depends on bbc_pkg.
module bbc_outq (
   input  logic                clock,
   input  logic                reset,
   input  bbc_pkg::rec_wr_type wr,
   output logic                room,
   output logic                empty,
   input  logic                pop,
   output bbc_pkg::rec_type    head,
   output logic [31:0]         head_total
);
   import bbc_pkg::*;

   rec_type          rec_mem [OQ_DEPTH];
   logic [31:0]      tot_mem [OQ_DEPTH];
   logic [OQ_AW:0]   wp_ff, cp_ff, rp_ff, used;
   logic [OQ_AW-1:0] tw_ff, tr_ff;
   logic             do_pop;

   assign empty      = (rp_ff == cp_ff);
   assign head       = rec_mem[rp_ff[OQ_AW-1:0]];
   assign head_total = tot_mem[tr_ff];
   assign used       = wp_ff - rp_ff;
   assign room       = used <= (OQ_AW + 1)'(OQ_DEPTH - MAX_REC);
   assign do_pop     = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         cp_ff <= '0;
         rp_ff <= '0;
         tw_ff <= '0;
         tr_ff <= '0;
      end else begin
         if (wr.valid) begin
            wp_ff <= wp_ff + (OQ_AW + 1)'(1);
            if (wr.commit) begin
               cp_ff <= wp_ff + (OQ_AW + 1)'(1);
               tw_ff <= tw_ff + OQ_AW'(1);
            end
         end
         if (do_pop) begin
            rp_ff <= rp_ff + (OQ_AW + 1)'(1);
            if (head.last) tr_ff <= tr_ff + OQ_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.valid) rec_mem[wp_ff[OQ_AW-1:0]] <= wr.rec;
      if (wr.valid && wr.commit) tot_mem[tw_ff] <= wr.total;
   end

endmodule
